### rtl/core/cwk_pkg.sv
// Package for the CW paddle keyer: word types, register indexes and reset values.
`timescale 1ns / 1ps

package cwk_pkg;

  // Configuration register index
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DOT_UNITS    = 4'd0,
    REG_UNIT_DIV     = 4'd1,
    REG_KEY_POLL_DIV = 4'd2,
    REG_TONE_DIV     = 4'd3
  } cfg_reg_t;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DotW     = 12;
  localparam int unsigned DivW     = 16;
  localparam int unsigned ElemW    = 14;

  // Register reset values
  localparam logic [DotW-1:0] DotUnitsRst   = 12'd150;
  localparam logic [DivW-1:0] UnitDivRst    = 16'd10;
  localparam logic [DivW-1:0] KeyPollDivRst = 16'd20;
  localparam logic [DivW-1:0] ToneDivRst    = 16'd25;

  // Input word: active-low paddle lines
  typedef struct packed {
    logic dah_level;
    logic dit_level;
  } in_word_t;

  // Result word: keyer outputs after the tick
  typedef struct packed {
    logic tx_on;
    logic carrier_on;
    logic tone_out;
    logic sending_dash;
  } out_word_t;

endpackage

### rtl/core/cw_paddle_keyer.sv
// CW paddle keyer: paddle polling, element timing and sidetone, one tick per word.
`timescale 1ns / 1ps
// A result word is registered in the output register when its input word is accepted.
// Throughput: one word per cycle unless the output register is full and stalled; all
//   per-tick updates are counter steps and flag logic between the state registers and the output register.
// in_ready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) restores register defaults and clears all keyer state.

module cw_paddle_keyer
  import cwk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic [DotW-1:0]  dot_units_r;
  logic [DivW-1:0]  unit_div_r;
  logic [DivW-1:0]  poll_div_r;
  logic [DivW-1:0]  tone_div_r;

  // Keyer state
  logic [DivW-1:0]  poll_cnt_r,   poll_cnt_nxt;
  logic [DivW-1:0]  tone_cnt_r,   tone_cnt_nxt;
  logic [DivW-1:0]  prescale_r,   prescale_nxt;
  logic [ElemW-1:0] elem_cnt_r,   elem_cnt_nxt;
  logic             dash_seen_r,  dash_seen_nxt;
  logic             dot_seen_r,   dot_seen_nxt;
  logic             dash_pend_r,  dash_pend_nxt;
  logic             dot_pend_r,   dot_pend_nxt;
  logic             sending_r,    sending_nxt;
  logic             tone_en_r,    tone_en_nxt;
  logic             tone_pin_r,   tone_pin_nxt;
  logic             carrier_r,    carrier_nxt;
  logic             is_dash_r,    is_dash_nxt;

  // Output register
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             in_fire;

  // Element timing terms
  logic [DotW-1:0]  dot_len;
  logic [DivW-1:0]  unit_len;
  logic [ElemW-1:0] mark_len;
  logic [ElemW:0]   period_len;
  logic             dah_pressed;
  logic             dit_pressed;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dah_pressed = !in_data.dah_level;
  assign dit_pressed = !in_data.dit_level;

  // Zero lengths act as one
  assign dot_len    = (dot_units_r == '0) ? DotW'(1) : dot_units_r;
  assign unit_len   = (unit_div_r == '0) ? DivW'(1) : unit_div_r;
  assign mark_len   = is_dash_r ? (ElemW'(dot_len) << 1) + ElemW'(dot_len)
                                : ElemW'(dot_len);
  assign period_len = (ElemW+1)'(mark_len) + (ElemW+1)'(dot_len);

  // One tick of keyer update
  always_comb begin
    logic [DivW-1:0]  pre_inc;
    logic [ElemW-1:0] cnt_inc;

    poll_cnt_nxt  = poll_cnt_r;
    tone_cnt_nxt  = tone_cnt_r;
    prescale_nxt  = prescale_r;
    elem_cnt_nxt  = elem_cnt_r;
    dash_seen_nxt = dash_seen_r;
    dot_seen_nxt  = dot_seen_r;
    dash_pend_nxt = dash_pend_r;
    dot_pend_nxt  = dot_pend_r;
    sending_nxt   = sending_r;
    tone_en_nxt   = tone_en_r;
    tone_pin_nxt  = tone_pin_r;
    carrier_nxt   = carrier_r;
    is_dash_nxt   = is_dash_r;
    pre_inc       = prescale_r + DivW'(1);
    cnt_inc       = elem_cnt_r + ElemW'(1);

    // paddle poll: two pressed samples in a row arm a request
    if (poll_cnt_r <= DivW'(1)) begin
      poll_cnt_nxt = poll_div_r;
      if (dah_pressed) begin
        if (dash_seen_r) begin
          if (!dot_pend_r) dash_pend_nxt = 1'b1;
        end else begin
          dash_seen_nxt = 1'b1;
        end
      end else begin
        dash_seen_nxt = 1'b0;
      end
      if (dit_pressed) begin
        if (dot_seen_r) begin
          if (!dash_pend_nxt) dot_pend_nxt = 1'b1;
        end else begin
          dot_seen_nxt = 1'b1;
        end
      end else begin
        dot_seen_nxt = 1'b0;
      end
    end else begin
      poll_cnt_nxt = poll_cnt_r - DivW'(1);
    end

    // sidetone divider
    if (tone_cnt_r <= DivW'(1)) begin
      tone_cnt_nxt = tone_div_r;
      if (tone_en_r) tone_pin_nxt = !tone_pin_r;
    end else begin
      tone_cnt_nxt = tone_cnt_r - DivW'(1);
    end

    // element timer
    if (sending_r) begin
      prescale_nxt = pre_inc;
      if (pre_inc >= unit_len) begin
        prescale_nxt = '0;
        elem_cnt_nxt = cnt_inc;
        // mark end
        if (cnt_inc == mark_len) begin
          tone_en_nxt   = 1'b0;
          carrier_nxt   = 1'b0;
          dash_pend_nxt = 1'b0;
          dot_pend_nxt  = 1'b0;
        end
        // period end: chain the next element or drop transmit
        if ((ElemW+1)'(cnt_inc) >= period_len) begin
          prescale_nxt = '0;
          elem_cnt_nxt = '0;
          if (dash_pend_nxt || dot_pend_nxt) begin
            sending_nxt = 1'b1;
            tone_en_nxt = 1'b1;
            carrier_nxt = 1'b1;
            is_dash_nxt = dash_pend_nxt;
          end else begin
            sending_nxt = 1'b0;
            tone_en_nxt = 1'b0;
            carrier_nxt = 1'b0;
          end
        end
      end
    end

    // idle start
    if (!sending_nxt && (dash_pend_nxt || dot_pend_nxt)) begin
      sending_nxt  = 1'b1;
      tone_en_nxt  = 1'b1;
      carrier_nxt  = 1'b1;
      is_dash_nxt  = dash_pend_nxt;
      prescale_nxt = '0;
      elem_cnt_nxt = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_units_r <= DotUnitsRst;
      unit_div_r  <= UnitDivRst;
      poll_div_r  <= KeyPollDivRst;
      tone_div_r  <= ToneDivRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOT_UNITS:    dot_units_r <= cfg_data[DotW-1:0];
        REG_UNIT_DIV:     unit_div_r  <= cfg_data[DivW-1:0];
        REG_KEY_POLL_DIV: poll_div_r  <= cfg_data[DivW-1:0];
        REG_TONE_DIV:     tone_div_r  <= cfg_data[DivW-1:0];
        default: ;
      endcase
    end
  end

  // Keyer state update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_cnt_r  <= KeyPollDivRst;
      tone_cnt_r  <= ToneDivRst;
      prescale_r  <= '0;
      elem_cnt_r  <= '0;
      dash_seen_r <= 1'b0;
      dot_seen_r  <= 1'b0;
      dash_pend_r <= 1'b0;
      dot_pend_r  <= 1'b0;
      sending_r   <= 1'b0;
      tone_en_r   <= 1'b0;
      tone_pin_r  <= 1'b0;
      carrier_r   <= 1'b0;
      is_dash_r   <= 1'b0;
    end else if (in_fire) begin
      poll_cnt_r  <= poll_cnt_nxt;
      tone_cnt_r  <= tone_cnt_nxt;
      prescale_r  <= prescale_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      dash_seen_r <= dash_seen_nxt;
      dot_seen_r  <= dot_seen_nxt;
      dash_pend_r <= dash_pend_nxt;
      dot_pend_r  <= dot_pend_nxt;
      sending_r   <= sending_nxt;
      tone_en_r   <= tone_en_nxt;
      tone_pin_r  <= tone_pin_nxt;
      carrier_r   <= carrier_nxt;
      is_dash_r   <= is_dash_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.tx_on        <= sending_nxt;
      out_data_r.carrier_on   <= carrier_nxt;
      out_data_r.tone_out     <= tone_pin_nxt;
      out_data_r.sending_dash <= is_dash_nxt;
    end
  end

endmodule

### sim/tb.sv
// Testbench for the CW paddle keyer: paddle runs, register sweeps and a per-tick predictor.
`timescale 1ns / 1ps

module tb;
  import cwk_pkg::*;

  // Paddle line levels, active low
  localparam logic Pressed  = 1'b0;
  localparam logic Released = 1'b1;

  // Index with no register behind it; a write there must change nothing
  localparam logic [CfgIdxW-1:0] SpareRegIdx = 4'd9;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Idle control: when set, that side never waits
  logic steady_in  = 1'b0;
  logic steady_out = 1'b0;
  int   fail_count = 0;

  out_word_t keyer_expect_q[$];

  // Predictor registers
  logic [DotW-1:0]  dot_len_cfg  = DotUnitsRst;
  logic [DivW-1:0]  unit_div_cfg = UnitDivRst;
  logic [DivW-1:0]  poll_div_cfg = KeyPollDivRst;
  logic [DivW-1:0]  tone_div_cfg = ToneDivRst;

  // Predictor keyer state
  logic [DivW-1:0]  poll_cnt  = KeyPollDivRst;
  logic [DivW-1:0]  tone_cnt  = ToneDivRst;
  logic [DivW-1:0]  unit_pre  = '0;
  logic [ElemW-1:0] elem_cnt  = '0;
  logic dah_seen = 1'b0, dit_seen = 1'b0, dah_req = 1'b0, dit_req = 1'b0;
  logic tx_active = 1'b0, tone_gate = 1'b0, tone_lvl = 1'b0, carrier_lvl = 1'b0;
  logic elem_dash = 1'b0;

  cw_paddle_keyer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Start an element: dash wins when both are requested
  function automatic void begin_element();
    tx_active = 1'b1;
    if (dah_req) begin
      elem_dash = 1'b1;
    end else if (dit_req) begin
      elem_dash = 1'b0;
    end
    tone_gate   = 1'b1;
    carrier_lvl = 1'b1;
    unit_pre    = '0;
    elem_cnt    = '0;
  endfunction

  // One base tick: poll, sidetone, element timer, idle start
  function automatic out_word_t keyer_tick(input in_word_t w);
    int dot, mark, span, pre, unit_div;
    out_word_t r;
    if (poll_cnt <= 1) begin
      poll_cnt = poll_div_cfg;
      if (!w.dah_level) begin
        if (dah_seen) begin
          if (!dit_req) dah_req = 1'b1;
        end else begin
          dah_seen = 1'b1;
        end
      end else begin
        dah_seen = 1'b0;
      end
      if (!w.dit_level) begin
        if (dit_seen) begin
          if (!dah_req) dit_req = 1'b1;
        end else begin
          dit_seen = 1'b1;
        end
      end else begin
        dit_seen = 1'b0;
      end
    end else begin
      poll_cnt = poll_cnt - 1'b1;
    end

    if (tone_cnt <= 1) begin
      tone_cnt = tone_div_cfg;
      if (tone_gate) tone_lvl = !tone_lvl;
    end else begin
      tone_cnt = tone_cnt - 1'b1;
    end

    if (tx_active) begin
      dot      = (dot_len_cfg == 0) ? 1 : int'(dot_len_cfg);
      unit_div = (unit_div_cfg == 0) ? 1 : int'(unit_div_cfg);
      mark     = elem_dash ? 3 * dot : dot;
      span     = mark + dot;
      pre      = int'(unit_pre) + 1;
      if (pre >= unit_div) begin
        unit_pre = '0;
        elem_cnt = elem_cnt + 1'b1;
        // mark over: key up and forget requests made during it
        if (int'(elem_cnt) == mark) begin
          tone_gate   = 1'b0;
          carrier_lvl = 1'b0;
          dah_req     = 1'b0;
          dit_req     = 1'b0;
        end
        if (int'(elem_cnt) >= span) begin
          if (dah_req || dit_req) begin
            begin_element();
          end else begin
            tx_active   = 1'b0;
            tone_gate   = 1'b0;
            carrier_lvl = 1'b0;
            unit_pre    = '0;
            elem_cnt    = '0;
          end
        end
      end else begin
        unit_pre = DivW'(pre);
      end
    end

    if (!tx_active && (dah_req || dit_req)) begin_element();

    r.tx_on        = tx_active;
    r.carrier_on   = carrier_lvl;
    r.tone_out     = tone_lvl;
    r.sending_dash = elem_dash;
    return r;
  endfunction

  // Send one tick word after a random gap; valid stays up into the next call
  task automatic send_tick(input in_word_t w);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keyer_expect_q.push_back(keyer_tick(w));
  endtask

  task automatic hold_paddles(input logic dah, input logic dit, input int n);
    in_word_t w;
    w.dah_level = dah;
    w.dit_level = dit;
    repeat (n) send_tick(w);
  endtask

  // Mostly held paddle runs, some single-tick chatter
  task automatic play_runs(input int n_items, input int noise_pct);
    int sent, len, k;
    logic [1:0] lv;
    in_word_t w;
    sent = 0;
    while (sent < n_items) begin
      lv = 2'($urandom_range(0, 3));
      w  = lv;
      if ($urandom_range(1, 100) <= noise_pct) begin
        len = 1;
      end else if (lv == 2'b11) begin
        len = $urandom_range(1, 6);
      end else begin
        len = $urandom_range(2, 24);
      end
      for (k = 0; k < len && sent < n_items; k++) begin
        send_tick(w);
        sent++;
      end
    end
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (keyer_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DOT_UNITS:    dot_len_cfg  = val[DotW-1:0];
      REG_UNIT_DIV:     unit_div_cfg = val;
      REG_KEY_POLL_DIV: poll_div_cfg = val;
      REG_TONE_DIV:     tone_div_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CfgDataW-1:0] dot, input logic [CfgDataW-1:0] unit_div,
                            input logic [CfgDataW-1:0] poll_div,
                            input logic [CfgDataW-1:0] tone_div);
    settle();
    write_reg(REG_DOT_UNITS, dot);
    write_reg(REG_UNIT_DIV, unit_div);
    write_reg(REG_KEY_POLL_DIV, poll_div);
    write_reg(REG_TONE_DIV, tone_div);
    cfg_valid <= 1'b0;
  endtask

  // Zero registers act as one; poll and tone counts from reset run out first.
  // Covers all paddle combinations, idle start, dash mark end, restart at period end.
  task automatic test_paddle_extremes();
    steady_in  = 1'b0;
    steady_out = 1'b0;
    set_timing('0, '0, '0, '0);
    hold_paddles(Released, Released, 1);
    hold_paddles(Pressed, Released, 1);
    hold_paddles(Released, Pressed, 1);
    hold_paddles(Pressed, Pressed, 1);
    hold_paddles(Released, Released, 15);
    hold_paddles(Pressed, Released, 4);
    hold_paddles(Released, Pressed, 2);
  endtask

  // Well-formed keying at quick timing, with and without idle cycles
  task automatic test_iambic_runs();
    steady_in  = 1'b1;
    steady_out = 1'b1;
    set_timing(16'd2, 16'd1, 16'd2, 16'd3);
    play_runs(100, 5);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    set_timing(16'd1, 16'd2, 16'd1, 16'd1);
    play_runs(100, 5);
    steady_in  = 1'b1;
    set_timing(16'd3, 16'd1, 16'd3, 16'd2);
    play_runs(100, 5);
  endtask

  // Random small settings; divisor changes land mid-count
  task automatic test_timing_sweep();
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      steady_in  = ($urandom_range(0, 2) == 0);
      steady_out = ($urandom_range(0, 2) == 0);
      set_timing(16'($urandom_range(0, 4)), 16'($urandom_range(1, 3)),
                 16'($urandom_range(1, 4)), 16'($urandom_range(1, 5)));
      play_runs(35, 10);
    end
  endtask

  // Paddle chatter with new random levels on every tick
  task automatic test_paddle_noise();
    steady_in  = 1'b0;
    steady_out = 1'b1;
    set_timing(16'd1, 16'd1, 16'd1, 16'd1);
    play_runs(60, 100);
  endtask

  // Largest register values; upper data bits of the dot length are dropped
  task automatic test_register_limits();
    steady_in  = 1'b0;
    steady_out = 1'b0;
    set_timing(16'hFFFF, 16'd1, 16'd1, 16'd1);
    settle();
    write_reg(SpareRegIdx, 16'hFFFF);
    cfg_valid <= 1'b0;
    hold_paddles(Pressed, Released, 10);
    hold_paddles(Pressed, Pressed, 10);
    hold_paddles(Released, Released, 10);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    play_runs(20, 20);
  endtask

  // Result side: random stalls, each accepted word checked against the oldest prediction
  task automatic check_field(input string what, input logic want, input logic got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, what, want, got);
    end
  endtask

  initial begin : result_monitor
    int stall;
    out_word_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (keyer_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: result word %b with nothing expected", $time, out_data);
      end else begin
        want = keyer_expect_q.pop_front();
        check_field("tx_on", want.tx_on, out_data.tx_on);
        check_field("carrier_on", want.carrier_on, out_data.carrier_on);
        check_field("tone_out", want.tone_out, out_data.tone_out);
        check_field("sending_dash", want.sending_dash, out_data.sending_dash);
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_paddle_extremes();
    test_iambic_runs();
    test_timing_sweep();
    test_paddle_noise();
    test_register_limits();

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
